// File: rtl/chir_pkg.sv
// chir_pkg: shared types, codes and helpers of the chunked image receiver
// depends on nothing; used by the interfaces, chir_ctrl, chir_store and the top level
`default_nettype none

package chir_pkg;

	// default sizes of the image store and of one chunk
	localparam int IMAGE_DEPTH_DEF = 65536;
	localparam int CHUNK_MAX_DEF   = 1024;

	// field widths
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 16;
	localparam int EV_W     = 2;
	localparam int IDX_W    = 16;
	localparam int IMG_W    = 17;
	localparam int CFG_IDX_W = 2;

	// frame format
	localparam logic [2:0] HDR_LEN  = 3'd7;
	localparam logic [7:0] CRC_POLY = 8'h07;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NACK_CODE    = 2'd2;

	// configuration reset values
	localparam logic [7:0] START_MARKER_RST = 8'd170;
	localparam logic [7:0] ACK_CODE_RST     = 8'd6;
	localparam logic [7:0] NACK_CODE_RST    = 8'd21;

	typedef enum logic [OP_W-1:0] {
		OP_BYTE    = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_READ    = 2'd2,
		OP_START   = 2'd3
	} op_t;

	typedef enum logic [EV_W-1:0] {
		EV_ACK      = 2'd0,
		EV_NACK     = 2'd1,
		EV_READ     = 2'd2,
		EV_OVERFLOW = 2'd3
	} ev_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HUNT    = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CHECK   = 3'd4,
		PH_DONE    = 3'd5,
		PH_ERROR   = 3'd6
	} phase_t;

	// result of one item, read data joined later
	typedef struct packed {
		logic              valid;
		ev_t               ev;
		logic [BYTE_W-1:0] reply;
		logic              done;
		logic [IDX_W-1:0]  index;
		logic [IMG_W-1:0]  image_bytes;
	} res_t;

	// crc-8, msb first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/chir_if.sv
// chir_in_if and chir_out_if: valid/ready channels of the receiver
// depends on chir_pkg for the field widths
`default_nettype none

interface chir_in_if;
	logic                          valid;
	logic                          ready;
	logic [chir_pkg::OP_W-1:0]     operation;
	logic [chir_pkg::BYTE_W-1:0]   rx_byte;
	logic [chir_pkg::ADDR_W-1:0]   read_address;

	modport source(output valid, operation, rx_byte, read_address, input ready);
	modport sink(input valid, operation, rx_byte, read_address, output ready);
endinterface

interface chir_out_if;
	logic                          valid;
	logic                          ready;
	logic [chir_pkg::EV_W-1:0]     event_res;
	logic [chir_pkg::BYTE_W-1:0]   reply_byte;
	logic                          transfer_done;
	logic [chir_pkg::IDX_W-1:0]    accepted_index;
	logic [chir_pkg::IMG_W-1:0]    image_bytes;
	logic [chir_pkg::BYTE_W-1:0]   read_data;

	modport source(output valid, event_res, reply_byte, transfer_done, accepted_index,
		image_bytes, read_data, input ready);
	modport sink(input valid, event_res, reply_byte, transfer_done, accepted_index,
		image_bytes, read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/chir_store.sv
// chir_store: image byte memory, one write port and one registered read port
// depends on chir_pkg for widths
`default_nettype none

module chir_store #(
	parameter int IMAGE_DEPTH = chir_pkg::IMAGE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(IMAGE_DEPTH)-1:0] wr_addr,
	input  wire logic [chir_pkg::BYTE_W-1:0]    wr_data,
	input  wire logic                           rd_en,
	input  wire logic [chir_pkg::ADDR_W-1:0]    rd_addr,
	output logic      [chir_pkg::BYTE_W-1:0]    rd_data
);

	localparam int AW = $clog2(IMAGE_DEPTH);

	logic [chir_pkg::BYTE_W-1:0] mem [IMAGE_DEPTH];
	logic [chir_pkg::BYTE_W-1:0] rd_q;
	logic                        rd_oob_q;
	logic                        rd_oob;

	// addresses at or beyond the depth read as zero
	assign rd_oob = 32'(rd_addr) >= 32'(IMAGE_DEPTH);

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q     <= mem[AW'(rd_addr)];
			rd_oob_q <= rd_oob;
		end
	end

	assign rd_data = rd_oob_q ? '0 : rd_q;

endmodule

`default_nettype wire

// File: rtl/chir_ctrl.sv
// chir_ctrl: framing state machine, crc check, commit logic and config registers
// depends on chir_pkg; drives the write port of chir_store
`default_nettype none

module chir_ctrl #(
	parameter int IMAGE_DEPTH = chir_pkg::IMAGE_DEPTH_DEF,
	parameter int CHUNK_MAX   = chir_pkg::CHUNK_MAX_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              take,
	input  wire logic [chir_pkg::OP_W-1:0]         operation,
	input  wire logic [chir_pkg::BYTE_W-1:0]       rx_byte,
	input  wire logic                              cfg_we,
	input  wire logic [chir_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [chir_pkg::BYTE_W-1:0]       cfg_data,
	output chir_pkg::res_t                         res,
	output logic                                   wr_en,
	output logic      [$clog2(IMAGE_DEPTH)-1:0]    wr_addr,
	output logic      [chir_pkg::BYTE_W-1:0]       wr_data
);

	localparam int AW    = $clog2(IMAGE_DEPTH);
	localparam int CW    = $clog2(IMAGE_DEPTH + 1);
	localparam int PW    = $clog2(CHUNK_MAX + 1);
	localparam int WS_W  = ((CW > PW) ? CW : PW) + 1;
	localparam int CS_W  = ((CW > 16) ? CW : 16) + 1;

	chir_pkg::phase_t phase_q, phase_d;
	logic [2:0]       hdr_cnt_q, hdr_cnt_d;
	logic [15:0]      frame_index_q, frame_index_d;
	logic [15:0]      frame_total_q, frame_total_d;
	logic [15:0]      frame_size_q, frame_size_d;
	logic [7:0]       crc_q, crc_d;
	logic [PW-1:0]    pay_cnt_q, pay_cnt_d;
	logic [CW-1:0]    committed_q, committed_d;
	logic [15:0]      expected_q, expected_d;
	logic [7:0]       start_marker_q, ack_code_q, nack_code_q;

	chir_pkg::op_t    op;
	logic [7:0]       crc_base, crc_next;
	logic [15:0]      size_shift;
	logic             hdr_last, size_big, pay_last, in_range, chk_bad, ovf, last_chunk;
	logic             in_frame, is_marker;
	logic [PW:0]      pay_next;
	logic [WS_W-1:0]  wr_sum;
	logic [CS_W-1:0]  commit_sum;

	assign op = chir_pkg::op_t'(operation);

	// shared conditions
	assign crc_base   = (phase_q == chir_pkg::PH_HUNT) ? 8'd0 : crc_q;
	assign crc_next   = chir_pkg::crc8_byte(crc_base, rx_byte);
	assign is_marker  = rx_byte == start_marker_q;
	assign size_shift = {frame_size_q[7:0], rx_byte};
	assign hdr_last   = hdr_cnt_q == (chir_pkg::HDR_LEN - 3'd1);
	assign size_big   = {16'd0, size_shift} > 32'(CHUNK_MAX);
	assign pay_next   = {1'b0, pay_cnt_q} + (PW+1)'(1);
	assign pay_last   = 17'(pay_next) >= {1'b0, frame_size_q};
	assign wr_sum     = WS_W'(committed_q) + WS_W'(pay_cnt_q);
	assign in_range   = wr_sum < WS_W'(IMAGE_DEPTH);
	assign commit_sum = CS_W'(committed_q) + CS_W'(frame_size_q);
	assign ovf        = commit_sum > CS_W'(IMAGE_DEPTH);
	assign chk_bad    = (rx_byte != crc_q) || (frame_index_q != expected_q);
	assign last_chunk = ({1'b0, frame_index_q} + 17'd1) >= {1'b0, frame_total_q};
	assign in_frame   = (phase_q == chir_pkg::PH_HUNT) || (phase_q == chir_pkg::PH_HEADER) ||
		(phase_q == chir_pkg::PH_PAYLOAD) || (phase_q == chir_pkg::PH_CHECK);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (op)
				chir_pkg::OP_BYTE: begin
					unique case (phase_q)
						chir_pkg::PH_HUNT: begin
							if (is_marker) phase_d = chir_pkg::PH_HEADER;
						end
						chir_pkg::PH_HEADER: begin
							if (hdr_last) begin
								if (size_big)
									phase_d = chir_pkg::PH_HUNT;
								else if (size_shift == 16'd0)
									phase_d = chir_pkg::PH_CHECK;
								else
									phase_d = chir_pkg::PH_PAYLOAD;
							end
						end
						chir_pkg::PH_PAYLOAD: begin
							if (pay_last) phase_d = chir_pkg::PH_CHECK;
						end
						chir_pkg::PH_CHECK: begin
							priority if (chk_bad)
								phase_d = chir_pkg::PH_HUNT;
							else if (ovf)
								phase_d = chir_pkg::PH_ERROR;
							else
								phase_d = last_chunk ? chir_pkg::PH_DONE : chir_pkg::PH_HUNT;
						end
						default: ;
					endcase
				end
				chir_pkg::OP_TIMEOUT: begin
					if (in_frame) phase_d = chir_pkg::PH_HUNT;
				end
				chir_pkg::OP_READ: ;
				chir_pkg::OP_START: phase_d = chir_pkg::PH_HUNT;
			endcase
		end
	end

	// datapath updates, result and store write
	always_comb begin
		hdr_cnt_d     = hdr_cnt_q;
		frame_index_d = frame_index_q;
		frame_total_d = frame_total_q;
		frame_size_d  = frame_size_q;
		crc_d         = crc_q;
		pay_cnt_d     = pay_cnt_q;
		committed_d   = committed_q;
		expected_d    = expected_q;
		res.valid     = 1'b0;
		res.ev        = chir_pkg::EV_NACK;
		res.reply     = 8'd0;
		res.done      = 1'b0;
		res.index     = 16'd0;
		wr_en         = 1'b0;
		wr_addr       = AW'(wr_sum);
		wr_data       = rx_byte;
		if (take) begin
			unique case (op)
				chir_pkg::OP_BYTE: begin
					unique case (phase_q)
						chir_pkg::PH_HUNT: begin
							if (is_marker) begin
								crc_d     = crc_next;
								hdr_cnt_d = 3'd1;
							end
						end
						chir_pkg::PH_HEADER: begin
							crc_d = crc_next;
							if (hdr_cnt_q <= 3'd2)
								frame_index_d = {frame_index_q[7:0], rx_byte};
							else if (hdr_cnt_q <= 3'd4)
								frame_total_d = {frame_total_q[7:0], rx_byte};
							else
								frame_size_d = size_shift;
							hdr_cnt_d = hdr_cnt_q + 3'd1;
							if (hdr_last) begin
								if (size_big) begin
									// oversized chunk is refused at once
									hdr_cnt_d = 3'd0;
									res.valid = 1'b1;
									res.ev    = chir_pkg::EV_NACK;
									res.reply = nack_code_q;
									res.index = frame_index_q;
								end else begin
									pay_cnt_d = '0;
								end
							end
						end
						chir_pkg::PH_PAYLOAD: begin
							crc_d     = crc_q ^ rx_byte;
							wr_en     = in_range;
							pay_cnt_d = PW'(pay_next);
						end
						chir_pkg::PH_CHECK: begin
							res.valid = 1'b1;
							res.index = frame_index_q;
							priority if (chk_bad) begin
								hdr_cnt_d = 3'd0;
								res.ev    = chir_pkg::EV_NACK;
								res.reply = nack_code_q;
							end else if (ovf) begin
								res.ev    = chir_pkg::EV_OVERFLOW;
							end else begin
								committed_d = CW'(commit_sum);
								expected_d  = expected_q + 16'd1;
								hdr_cnt_d   = 3'd0;
								res.ev      = chir_pkg::EV_ACK;
								res.reply   = ack_code_q;
								res.done    = last_chunk;
							end
						end
						default: ;
					endcase
				end
				chir_pkg::OP_TIMEOUT: begin
					if (in_frame) begin
						hdr_cnt_d = 3'd0;
						res.valid = 1'b1;
						res.ev    = chir_pkg::EV_NACK;
						res.reply = nack_code_q;
					end
				end
				chir_pkg::OP_READ: begin
					res.valid = 1'b1;
					res.ev    = chir_pkg::EV_READ;
				end
				chir_pkg::OP_START: begin
					committed_d = '0;
					expected_d  = 16'd0;
					hdr_cnt_d   = 3'd0;
					pay_cnt_d   = '0;
					crc_d       = 8'd0;
				end
			endcase
		end
		res.image_bytes = 17'(committed_d);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= chir_pkg::PH_IDLE;
			hdr_cnt_q     <= 3'd0;
			frame_index_q <= 16'd0;
			frame_total_q <= 16'd0;
			frame_size_q  <= 16'd0;
			crc_q         <= 8'd0;
			pay_cnt_q     <= '0;
			committed_q   <= '0;
			expected_q    <= 16'd0;
		end else begin
			phase_q       <= phase_d;
			hdr_cnt_q     <= hdr_cnt_d;
			frame_index_q <= frame_index_d;
			frame_total_q <= frame_total_d;
			frame_size_q  <= frame_size_d;
			crc_q         <= crc_d;
			pay_cnt_q     <= pay_cnt_d;
			committed_q   <= committed_d;
			expected_q    <= expected_d;
		end
	end

	// configuration registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= chir_pkg::START_MARKER_RST;
			ack_code_q     <= chir_pkg::ACK_CODE_RST;
			nack_code_q    <= chir_pkg::NACK_CODE_RST;
		end else if (cfg_we) begin
			if (cfg_index == chir_pkg::CFG_START_MARKER) start_marker_q <= cfg_data;
			if (cfg_index == chir_pkg::CFG_ACK_CODE)     ack_code_q     <= cfg_data;
			if (cfg_index == chir_pkg::CFG_NACK_CODE)    nack_code_q    <= cfg_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/chunked_image_receiver_core.sv
// chunked_image_receiver_core: stop-and-wait chunk receiver, header crc-8 and payload xor check, image store
// a result passes stage 1 and then the output register on its way from in_ch to out_ch,
// and stays on out_ch while out_ch stalls
// throughput: one item per cycle while out_ch keeps up; a result held in stage 1 behind a
// full output register stops in_ch until the output transfer
// reset: control state and config registers return to their reset values at once; the image
// store is not cleared and holds undefined data until written, so no clearing pass is run
`default_nettype none

module chunked_image_receiver_core #(
	parameter int IMAGE_DEPTH = chir_pkg::IMAGE_DEPTH_DEF,
	parameter int CHUNK_MAX   = chir_pkg::CHUNK_MAX_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	chir_in_if.sink                             in_ch,
	chir_out_if.source                          out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [chir_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [chir_pkg::BYTE_W-1:0]    cfg_data
);

	localparam int AW = $clog2(IMAGE_DEPTH);

	chir_pkg::res_t              res, res_s1, res_q;
	logic                        valid_s1, out_valid_q;
	logic [chir_pkg::BYTE_W-1:0] read_data_q;
	logic                        accept, s1_move, rd_en;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [chir_pkg::BYTE_W-1:0] wr_data, rd_data;

	// input transfer, the store read issues with it
	assign s1_move     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || s1_move;
	assign accept      = in_ch.valid && in_ch.ready;
	assign rd_en       = accept && (in_ch.operation == chir_pkg::OP_READ);

	chir_ctrl #(
		.IMAGE_DEPTH(IMAGE_DEPTH),
		.CHUNK_MAX  (CHUNK_MAX)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (accept),
		.operation(in_ch.operation),
		.rx_byte  (in_ch.rx_byte),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// one item a cycle never hits the same entry with a read and a write together
	chir_store #(
		.IMAGE_DEPTH(IMAGE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(in_ch.read_address),
		.rd_data(rd_data)
	);

	// stage 1 valid and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && res.valid)
				valid_s1 <= 1'b1;
			else if (s1_move)
				valid_s1 <= 1'b0;
			if (s1_move)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	// stage 1 payload waits for the store read data
	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			res_s1 <= res;
		end
	end

	// output register joins read data
	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_q       <= res_s1;
			read_data_q <= (res_s1.ev == chir_pkg::EV_READ) ? rd_data : '0;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.event_res      = res_q.ev;
	assign out_ch.reply_byte     = res_q.reply;
	assign out_ch.transfer_done  = res_q.done;
	assign out_ch.accepted_index = res_q.index;
	assign out_ch.image_bytes    = res_q.image_bytes;
	assign out_ch.read_data      = read_data_q;

	// a held stage 1 result is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(res_s1))
		else $error("stage 1 result changed while held");

	// only reads carry store data
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.event_res != chir_pkg::EV_READ) |-> out_ch.read_data == 8'd0)
		else $error("read data on a non-read result");

	// the last-chunk flag comes only with an ack
	a_done_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.transfer_done |-> out_ch.event_res == chir_pkg::EV_ACK)
		else $error("transfer done without ack");

	// a result enters stage 1 only while a transfer is accepted
	a_s1_src: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 ##1 valid_s1 |-> $past(accept))
		else $error("stage 1 filled without an input transfer");

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench of chunked_image_receiver_core, driving chunk framing,
// timeouts, reads and starts over the valid/ready channels and the config port
// depends on chir_pkg and the chir_in_if/chir_out_if channel interfaces

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH  = chir_pkg::IMAGE_DEPTH_DEF;
	localparam int CHUNK_LIMIT  = chir_pkg::CHUNK_MAX_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 6;
	localparam int NO_CUT       = -1;

	// one expected result of the receiver
	typedef struct {
		chir_pkg::ev_t ev;
		logic [7:0]    reply;
		logic          done;
		logic [15:0]   index;
		logic [16:0]   image_bytes;
		logic [7:0]    read_data;
	} rx_event_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [chir_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [chir_pkg::BYTE_W-1:0]    cfg_data;

	chir_in_if  in_ch();
	chir_out_if out_ch();

	chunked_image_receiver_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// receiver state as the testbench sees it
	chir_pkg::phase_t rx_phase;
	logic [2:0]  hdr_count;
	logic [15:0] frm_index;
	logic [15:0] frm_total;
	logic [15:0] frm_size;
	logic [7:0]  crc_acc;
	int          pay_count;
	int          committed;
	logic [15:0] next_index;
	logic [7:0]  image_mem [STORE_DEPTH];
	bit          written_map [STORE_DEPTH];
	int          last_write;
	logic [7:0]  marker_reg;
	logic [7:0]  ack_reg;
	logic [7:0]  nack_reg;

	rx_event_t   awaited_events[$];
	int          fail_count;
	int          cycle_count;
	int          counted_items;
	int          send_idle_pct;
	int          recv_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("chunked_image_receiver_core verification failed");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// crc-8, poly 0x07, msb first
	function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++)
			c = {c[6:0], 1'b0} ^ (c[7] ? chir_pkg::CRC_POLY : 8'h00);
		return c;
	endfunction

	function automatic void clear_receiver_state();
		marker_reg = chir_pkg::START_MARKER_RST;
		ack_reg    = chir_pkg::ACK_CODE_RST;
		nack_reg   = chir_pkg::NACK_CODE_RST;
		rx_phase   = chir_pkg::PH_IDLE;
		hdr_count  = '0;
		frm_index  = '0;
		frm_total  = '0;
		frm_size   = '0;
		crc_acc    = '0;
		pay_count  = 0;
		committed  = 0;
		next_index = '0;
		last_write = -1;
		for (int i = 0; i < STORE_DEPTH; i++)
			written_map[i] = 1'b0;
	endfunction

	function automatic void queue_event(chir_pkg::ev_t ev, logic [7:0] reply, logic done,
		logic [15:0] idx, logic [7:0] rd);
		rx_event_t e;
		e.ev          = ev;
		e.reply       = reply;
		e.done        = done;
		e.index       = idx;
		e.image_bytes = committed[16:0];
		e.read_data   = rd;
		awaited_events.push_back(e);
	endfunction

	function automatic void reject_frame(logic [15:0] idx);
		rx_phase  = chir_pkg::PH_HUNT;
		hdr_count = '0;
		queue_event(chir_pkg::EV_NACK, nack_reg, 1'b0, idx, 8'h00);
	endfunction

	// framing of one link byte
	function automatic void take_link_byte(logic [7:0] b);
		int  addr;
		bit  final_chunk;
		case (rx_phase)
			chir_pkg::PH_HUNT: begin
				if (b == marker_reg) begin
					crc_acc   = crc8_next(8'h00, b);
					hdr_count = 3'd1;
					rx_phase  = chir_pkg::PH_HEADER;
				end
			end
			chir_pkg::PH_HEADER: begin
				crc_acc = crc8_next(crc_acc, b);
				if (hdr_count <= 3'd2)
					frm_index = {frm_index[7:0], b};
				else if (hdr_count <= 3'd4)
					frm_total = {frm_total[7:0], b};
				else
					frm_size = {frm_size[7:0], b};
				hdr_count = hdr_count + 3'd1;
				if (hdr_count == chir_pkg::HDR_LEN) begin
					if (frm_size > CHUNK_LIMIT) begin
						reject_frame(frm_index);
					end else begin
						pay_count = 0;
						rx_phase  = (frm_size == 0) ? chir_pkg::PH_CHECK : chir_pkg::PH_PAYLOAD;
					end
				end
			end
			chir_pkg::PH_PAYLOAD: begin
				crc_acc = crc_acc ^ b;
				addr    = committed + pay_count;
				if (addr < STORE_DEPTH) begin
					image_mem[addr]   = b;
					written_map[addr] = 1'b1;
					last_write        = addr;
				end
				pay_count++;
				if (pay_count >= frm_size)
					rx_phase = chir_pkg::PH_CHECK;
			end
			chir_pkg::PH_CHECK: begin
				if (b != crc_acc || frm_index != next_index) begin
					reject_frame(frm_index);
				end else if (committed + frm_size > STORE_DEPTH) begin
					rx_phase = chir_pkg::PH_ERROR;
					queue_event(chir_pkg::EV_OVERFLOW, 8'h00, 1'b0, frm_index, 8'h00);
				end else begin
					committed   = committed + frm_size;
					next_index  = next_index + 16'd1;
					final_chunk = ({1'b0, frm_index} + 17'd1) >= {1'b0, frm_total};
					rx_phase    = final_chunk ? chir_pkg::PH_DONE : chir_pkg::PH_HUNT;
					hdr_count   = '0;
					queue_event(chir_pkg::EV_ACK, ack_reg, final_chunk, frm_index, 8'h00);
				end
			end
			default: ;
		endcase
	endfunction

	// expected effect of one accepted item
	function automatic void advance_receiver(chir_pkg::op_t op, logic [7:0] b,
		logic [15:0] a);
		case (op)
			chir_pkg::OP_BYTE: take_link_byte(b);
			chir_pkg::OP_TIMEOUT: begin
				if (rx_phase == chir_pkg::PH_HUNT || rx_phase == chir_pkg::PH_HEADER ||
					rx_phase == chir_pkg::PH_PAYLOAD || rx_phase == chir_pkg::PH_CHECK)
					reject_frame(16'h0000);
			end
			chir_pkg::OP_READ:
				queue_event(chir_pkg::EV_READ, 8'h00, 1'b0, 16'h0000, image_mem[a]);
			default: begin
				committed  = 0;
				next_index = '0;
				hdr_count  = '0;
				pay_count  = 0;
				crc_acc    = '0;
				rx_phase   = chir_pkg::PH_HUNT;
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		rx_event_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_events.size() == 0) begin
				$error("result with none expected: event_res %0d accepted_index %0h",
					out_ch.event_res, out_ch.accepted_index);
				fail_count++;
			end else begin
				want = awaited_events.pop_front();
				check_field("event_res", want.ev, out_ch.event_res);
				check_field("reply_byte", want.reply, out_ch.reply_byte);
				check_field("transfer_done", want.done, out_ch.transfer_done);
				check_field("accepted_index", want.index, out_ch.accepted_index);
				check_field("image_bytes", want.image_bytes, out_ch.image_bytes);
				check_field("read_data", want.read_data, out_ch.read_data);
			end
		end
	end

	// one input transfer; entered and left at a falling edge
	task automatic send_item(chir_pkg::op_t op, logic [7:0] b, logic [15:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.operation    <= op;
		in_ch.rx_byte      <= b;
		in_ch.read_address <= a;
		do @(posedge clk); while (!in_ch.ready);
		counted_items++;
		advance_receiver(op, b, a);
		@(negedge clk);
	endtask

	// hold off the sender until every expected result has come back
	task automatic wait_for_drain();
		in_ch.valid <= 1'b0;
		while (awaited_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [chir_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		case (idx)
			chir_pkg::CFG_START_MARKER: marker_reg = v;
			chir_pkg::CFG_ACK_CODE:     ack_reg = v;
			chir_pkg::CFG_NACK_CODE:    nack_reg = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(logic [7:0] marker, logic [7:0] ack, logic [7:0] nack);
		wait_for_drain();
		write_register(chir_pkg::CFG_START_MARKER, marker);
		write_register(chir_pkg::CFG_ACK_CODE, ack);
		write_register(chir_pkg::CFG_NACK_CODE, nack);
	endtask

	// a framed chunk with random payload; cut_at puts a timeout at that byte position
	task automatic send_chunk(logic [15:0] idx, logic [15:0] total, logic [15:0] size,
		int cut_at, bit spoil);
		logic [7:0] hdr [7];
		logic [7:0] crc;
		logic [7:0] b;
		int         len;
		hdr[0] = marker_reg;
		hdr[1] = idx[15:8];
		hdr[2] = idx[7:0];
		hdr[3] = total[15:8];
		hdr[4] = total[7:0];
		hdr[5] = size[15:8];
		hdr[6] = size[7:0];
		crc    = 8'h00;
		len    = (size > CHUNK_LIMIT) ? 7 : 8 + size;
		for (int p = 0; p < len; p++) begin
			if (p == cut_at) begin
				send_item(chir_pkg::OP_TIMEOUT, 8'($urandom), 16'($urandom));
				return;
			end
			if (p < 7) begin
				b   = hdr[p];
				crc = crc8_next(crc, b);
			end else if (p < len - 1) begin
				b   = 8'($urandom);
				crc = crc ^ b;
			end else begin
				b = spoil ? crc ^ 8'(1 << $urandom_range(7)) : crc;
			end
			send_item(chir_pkg::OP_BYTE, b, 16'($urandom));
		end
	endtask

	function automatic logic [15:0] pick_read_address();
		logic [15:0] a;
		a = 16'($urandom);
		if (!written_map[a])
			a = 16'(last_write - $urandom_range(40));
		if (!written_map[a])
			a = 16'(last_write);
		return a;
	endfunction

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	// bytes and timeouts before any start are dropped
	task automatic test_idle_inputs();
		send_item(chir_pkg::OP_BYTE, chir_pkg::START_MARKER_RST, 16'hFFFF);
		send_item(chir_pkg::OP_BYTE, 8'hFF, 16'h0000);
		send_item(chir_pkg::OP_TIMEOUT, 8'h00, 16'h0000);
	endtask

	// one two-chunk transfer at reset register values
	task automatic test_single_transfer();
		send_item(chir_pkg::OP_START, 8'h00, 16'h0000);
		send_item(chir_pkg::OP_BYTE, 8'h00, 16'h0000);
		send_item(chir_pkg::OP_BYTE, 8'hFF, 16'hFFFF);
		send_chunk(16'd0, 16'd2, 16'd3, NO_CUT, 1'b0);
		send_item(chir_pkg::OP_READ, 8'hFF, 16'd0);
		send_item(chir_pkg::OP_READ, 8'h00, 16'd2);
		// empty last chunk goes straight to the check byte
		send_chunk(16'd1, 16'd2, 16'd0, NO_CUT, 1'b0);
		// done: link bytes and timeouts are ignored
		send_item(chir_pkg::OP_BYTE, marker_reg, 16'h0000);
		send_item(chir_pkg::OP_TIMEOUT, 8'h00, 16'h0000);
		send_item(chir_pkg::OP_READ, 8'h00, 16'd1);
	endtask

	// bad check, wrong index, oversized chunks and timeouts in every frame phase
	task automatic test_rejections();
		send_item(chir_pkg::OP_START, 8'h00, 16'h0000);
		send_chunk(16'd0, 16'd4, 16'd2, NO_CUT, 1'b1);
		send_chunk(16'd5, 16'd9, 16'd1, NO_CUT, 1'b0);
		send_chunk(16'd0, 16'd4, 16'(CHUNK_LIMIT + 1), NO_CUT, 1'b0);
		send_chunk(16'hFFFF, 16'hFFFF, 16'hFFFF, NO_CUT, 1'b0);
		send_item(chir_pkg::OP_TIMEOUT, 8'h5A, 16'h0000);
		send_chunk(16'd0, 16'd4, 16'd3, 3, 1'b0);
		send_chunk(16'd0, 16'd4, 16'd3, 8, 1'b0);
		send_chunk(16'd0, 16'd4, 16'd3, 10, 1'b0);
		// total of zero ends the transfer on the first chunk
		send_chunk(16'd0, 16'd0, 16'd1, NO_CUT, 1'b0);
	endtask

	// register extremes
	task automatic test_register_extremes();
		configure(8'h00, 8'hFF, 8'h00);
		send_item(chir_pkg::OP_START, 8'h00, 16'h0000);
		send_chunk(16'd0, 16'd3, 16'd2, NO_CUT, 1'b0);
		send_chunk(16'd1, 16'd3, 16'd2, NO_CUT, 1'b1);
		configure(8'hFF, 8'h00, 8'hFF);
		send_item(chir_pkg::OP_START, 8'h00, 16'h0000);
		send_chunk(16'd0, 16'd1, 16'd1, NO_CUT, 1'b0);
		send_item(chir_pkg::OP_START, 8'h00, 16'h0000);
		send_item(chir_pkg::OP_TIMEOUT, 8'h00, 16'h0000);
		configure(chir_pkg::START_MARKER_RST, chir_pkg::ACK_CODE_RST, chir_pkg::NACK_CODE_RST);
	endtask

	// room is the number of items still left in the budget of the caller
	task automatic send_random_chunk(int room);
		logic [15:0] idx;
		logic [15:0] total;
		logic [15:0] size;
		int          r;
		int          cut;
		idx = ($urandom_range(9) == 0) ? 16'($urandom) : next_index;
		r   = $urandom_range(9);
		if (r == 0)
			total = 16'h0000;
		else if (r == 1)
			total = 16'hFFFF;
		else
			total = idx + 16'd1 + 16'($urandom_range(6));
		r = $urandom_range(19);
		if (r == 0)
			size = 16'(CHUNK_LIMIT);
		else if (r == 1)
			size = 16'($urandom_range(65535, CHUNK_LIMIT + 1));
		else if (r == 2)
			size = 16'($urandom_range(CHUNK_LIMIT - 1, 13));
		else
			size = 16'($urandom_range(12));
		// a long chunk near the end of the budget is cut down to a short one
		if (size <= CHUNK_LIMIT && int'(size) + 8 > room)
			size = 16'($urandom_range(12));
		cut = NO_CUT;
		if ($urandom_range(19) == 0)
			cut = $urandom_range((size > CHUNK_LIMIT) ? 6 : 7 + size);
		send_chunk(idx, total, size, cut, $urandom_range(7) == 0);
	endtask

	// mostly well-formed chunks with random content, mixed with noise
	task automatic test_random_traffic(int quota);
		int target;
		int pick;
		int reg_pick;
		logic [7:0] v;
		target = counted_items + quota;
		while (counted_items < target) begin
			if ($urandom_range(149) == 0) begin
				wait_for_drain();
				pick     = $urandom_range(3);
				v        = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
				reg_pick = $urandom_range(2);
				write_register(chir_pkg::CFG_IDX_W'(reg_pick), v);
			end
			pick = $urandom_range(99);
			if ((rx_phase == chir_pkg::PH_IDLE || rx_phase == chir_pkg::PH_DONE ||
				rx_phase == chir_pkg::PH_ERROR) && $urandom_range(9) < 8)
				send_item(chir_pkg::OP_START, 8'($urandom), 16'($urandom));
			else if (pick < 60)
				send_random_chunk(target - counted_items);
			else if (pick < 75 && last_write >= 0)
				send_item(chir_pkg::OP_READ, 8'($urandom), pick_read_address());
			else if (pick < 85)
				send_item(chir_pkg::OP_BYTE, 8'($urandom), 16'($urandom));
			else if (pick < 93)
				send_item(chir_pkg::OP_TIMEOUT, 8'($urandom), 16'($urandom));
			else
				send_item(chir_pkg::OP_START, 8'($urandom), 16'($urandom));
		end
	endtask

	// test sequence
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = chir_pkg::CFG_START_MARKER;
		cfg_data           = '0;
		in_ch.valid        = 1'b0;
		in_ch.operation    = chir_pkg::OP_BYTE;
		in_ch.rx_byte      = '0;
		in_ch.read_address = '0;
		out_ch.ready       = 1'b0;
		fail_count         = 0;
		cycle_count        = 0;
		counted_items      = 0;
		clear_receiver_state();
		set_idling(16, 47);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_inputs();
		test_single_transfer();
		test_rejections();
		test_register_extremes();
		test_random_traffic(300);
		set_idling(47, 16);
		test_random_traffic(300);
		set_idling(0, 0);
		test_random_traffic(300);

		wait_for_drain();
		if (fail_count == 0)
			$display("chunked_image_receiver_core verification clean");
		else
			$display("chunked_image_receiver_core verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/chir_pkg.sv
rtl/chir_if.sv
rtl/chir_store.sv
rtl/chir_ctrl.sv
rtl/chunked_image_receiver_core.sv
tb/tb.sv
